/* design/lgg_pkg.sv */
`default_nettype none

package lgg_pkg;

    // default grid size
    localparam int unsigned C_GRID_WIDTH  = 5;
    localparam int unsigned C_GRID_HEIGHT = 7;

    // widest grid the row datapath supports
    localparam int unsigned C_MAX_WIDTH = 64;
    localparam int unsigned C_MAX_ROW_W = 6;

    // starting pattern, one entry per row, bit c is column c
    localparam int unsigned C_PATTERN_H = 7;
    localparam logic [7:0] C_START_PATTERN [C_PATTERN_H] = '{
        8'h06, 8'h09, 8'h11, 8'h0A, 8'h04, 8'h15, 8'h0A
    };

    // item operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_SWEEP,
        ST_LAST,
        ST_REPLY
    } t_state;

    // row memory port control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    // starting value of one row, zero below the pattern
    function automatic logic [C_MAX_WIDTH-1:0] start_row(input logic [C_MAX_ROW_W-1:0] idx);
        logic [C_MAX_WIDTH-1:0] v;
        v = '0;
        if (idx < C_MAX_ROW_W'(C_PATTERN_H)) begin
            v = C_MAX_WIDTH'(C_START_PATTERN[idx[2:0]]);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/lgg_row_rule.sv */
`default_nettype none

module lgg_row_rule #(
    parameter int unsigned GRID_WIDTH = 5
) (
    input  wire logic [GRID_WIDTH-1:0] i_above,
    input  wire logic [GRID_WIDTH-1:0] i_mid,
    input  wire logic [GRID_WIDTH-1:0] i_below,
    output logic      [GRID_WIDTH-1:0] o_next
);
    import lgg_pkg::*;

    logic [GRID_WIDTH+1:0] w_a;
    logic [GRID_WIDTH+1:0] w_m;
    logic [GRID_WIDTH+1:0] w_b;

    // dead cells pad both edges
    assign w_a = {1'b0, i_above, 1'b0};
    assign w_m = {1'b0, i_mid, 1'b0};
    assign w_b = {1'b0, i_below, 1'b0};

    // one neighbor count and rule per column
    always_comb begin
        logic [3:0] cnt;
        for (int c = 0; c < GRID_WIDTH; c++) begin
            cnt = 4'(w_a[c]) + 4'(w_a[c+1]) + 4'(w_a[c+2])
                + 4'(w_m[c])                + 4'(w_m[c+2])
                + 4'(w_b[c]) + 4'(w_b[c+1]) + 4'(w_b[c+2]);
            o_next[c] = (cnt == 4'd3) || (i_mid[c] && (cnt == 4'd2));
        end
    end

endmodule

`default_nettype wire

/* design/lgg_grid_mem.sv */
`default_nettype none

module lgg_grid_mem #(
    parameter int unsigned GRID_WIDTH  = 5,
    parameter int unsigned GRID_HEIGHT = 7,
    localparam int unsigned ROW_W      = $clog2(GRID_HEIGHT)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lgg_pkg::t_mem_ctl     i_ctl,
    input  wire logic [ROW_W-1:0]      i_raddr,
    input  wire logic [ROW_W-1:0]      i_waddr,
    input  wire logic [GRID_WIDTH-1:0] i_wdata,
    output logic      [GRID_WIDTH-1:0] o_rdata
);
    import lgg_pkg::*;

    logic [GRID_WIDTH-1:0] r_mem [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0] r_rd_data;
    logic [ROW_W-1:0]      r_rd_addr;
    logic                  r_rd_hit;
    logic [GRID_HEIGHT-1:0] r_row_valid;
    logic [C_MAX_WIDTH-1:0] w_start;

    // row storage, one row per entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_raddr];
            r_rd_addr <= i_raddr;
        end
    end

    // rows not yet written read as the starting pattern
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_hit    <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_row_valid[i_waddr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_hit <= r_row_valid[i_raddr];
            end
        end
    end

    assign w_start = start_row(C_MAX_ROW_W'(r_rd_addr));
    assign o_rdata = r_rd_hit ? r_rd_data : w_start[GRID_WIDTH-1:0];

`ifndef SYNTHESIS
    // a row is never read and written in the same cycle
    a_no_rw_same_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.rd_en && i_ctl.wr_en) |-> (i_raddr != i_waddr))
        else $error("row read and written in one cycle");

    // a written row is marked valid from then on
    a_valid_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_ctl.wr_en)) |-> r_row_valid[$past(i_waddr)])
        else $error("written row not marked valid");
`endif

endmodule

`default_nettype wire

/* design/life_grid_generation_engine.sv */
`default_nettype none

// Bounded life grid: GRID_WIDTH x GRID_HEIGHT one-bit cells kept one row per
// entry in a synchronous memory, starting from the built-in pattern after
// reset. Each item writes a cell (op 0), advances one generation (op 1) or
// reads a cell (op 2); every item returns one result item, the cell value on
// a read and 0 otherwise. Cells outside the grid are dead, writes outside are
// dropped and reads outside return 0. A write or read on the grid steps
// through a row read, a modify or pick, and the result; an off-grid write
// or read and an unused op go straight to the result. In a generation the
// single read port delivers one row per cycle into a three-row window, and
// the new row behind the window is written back in the same cycle. One item
// is in work at a time; the result register lets the next item enter while a
// result still waits to be taken, and an item whose result is ready waits,
// with the input stalled, for as long as that held result is not taken.
module life_grid_generation_engine #(
    parameter int unsigned GRID_WIDTH  = lgg_pkg::C_GRID_WIDTH,
    parameter int unsigned GRID_HEIGHT = lgg_pkg::C_GRID_HEIGHT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_op,
    input  wire logic [2:0] i_col,
    input  wire logic [2:0] i_row,
    input  wire logic       i_cell_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_cell_out
);
    import lgg_pkg::*;

    localparam int unsigned COL_W = $clog2(GRID_WIDTH);
    localparam int unsigned ROW_W = $clog2(GRID_HEIGHT);

    t_state                r_state, n_state;
    logic [ROW_W-1:0]      r_cnt, n_cnt;
    logic [ROW_W-1:0]      r_addr, n_addr;
    logic [COL_W-1:0]      r_col, n_col;
    logic                  r_val, n_val;
    logic                  r_is_read, n_is_read;
    logic                  r_res, n_res;
    logic [GRID_WIDTH-1:0] r_prev, n_prev;
    logic [GRID_WIDTH-1:0] r_cur, n_cur;
    logic                  r_out_valid;
    logic                  r_cell_out;
    logic                  out_load;

    t_mem_ctl              mem_ctl;
    logic [ROW_W-1:0]      mem_raddr;
    logic [ROW_W-1:0]      mem_waddr;
    logic [GRID_WIDTH-1:0] mem_wdata;
    logic [GRID_WIDTH-1:0] rd_row;
    logic [GRID_WIDTH-1:0] rule_below;
    logic [GRID_WIDTH-1:0] rule_row;

    logic                  w_inside;
    logic [ROW_W+2:0]      w_row_ext;
    logic [COL_W+2:0]      w_col_ext;
    logic [ROW_W-1:0]      w_row_idx;
    logic [COL_W-1:0]      w_col_idx;

    // row memory
    lgg_grid_mem #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mem_ctl),
        .i_raddr(mem_raddr),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .o_rdata(rd_row)
    );

    // next row from the three-row window
    lgg_row_rule #(
        .GRID_WIDTH(GRID_WIDTH)
    ) u_rule (
        .i_above(r_prev),
        .i_mid  (r_cur),
        .i_below(rule_below),
        .o_next (rule_row)
    );

    // coordinate decode
    assign w_inside  = ({4'b0, i_col} < 7'(GRID_WIDTH)) && ({4'b0, i_row} < 7'(GRID_HEIGHT));
    assign w_row_ext = {{ROW_W{1'b0}}, i_row};
    assign w_col_ext = {{COL_W{1'b0}}, i_col};
    assign w_row_idx = w_row_ext[ROW_W-1:0];
    assign w_col_idx = w_col_ext[COL_W-1:0];

    assign o_in_stall = (r_state != ST_IDLE);

    // sequencer next state and memory control
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_addr     = r_addr;
        n_col      = r_col;
        n_val      = r_val;
        n_is_read  = r_is_read;
        n_res      = r_res;
        n_prev     = r_prev;
        n_cur      = r_cur;
        mem_ctl    = '0;
        mem_raddr  = r_addr;
        mem_waddr  = r_addr;
        mem_wdata  = rule_row;
        rule_below = rd_row;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res = 1'b0;
                    unique case (i_op) inside
                        OP_STEP: begin
                            mem_ctl.rd_en = 1'b1;
                            mem_raddr     = '0;
                            n_cnt         = '0;
                            n_prev        = '0;
                            n_cur         = '0;
                            n_state       = ST_SWEEP;
                        end
                        OP_WRITE, OP_READ: begin
                            if (w_inside) begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = w_row_idx;
                                n_addr        = w_row_idx;
                                n_col         = w_col_idx;
                                n_val         = i_cell_in;
                                n_is_read     = (i_op == OP_READ);
                                n_state       = ST_RMW;
                            end else begin
                                n_state = ST_REPLY;
                            end
                        end
                        default: begin
                            n_state = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                if (r_is_read) begin
                    n_res = rd_row[r_col];
                end else begin
                    mem_ctl.wr_en = 1'b1;
                    mem_waddr     = r_addr;
                    mem_wdata     = (rd_row & ~(GRID_WIDTH'(1) << r_col))
                                  | (GRID_WIDTH'(r_val) << r_col);
                end
                n_state = ST_REPLY;
            end
            ST_SWEEP: begin
                // fetch the row after the one arriving now
                if (r_cnt != ROW_W'(GRID_HEIGHT - 1)) begin
                    mem_ctl.rd_en = 1'b1;
                    mem_raddr     = r_cnt + ROW_W'(1);
                end else begin
                    n_state = ST_LAST;
                end
                // new row behind the arriving one is complete
                if (r_cnt != '0) begin
                    mem_ctl.wr_en = 1'b1;
                    mem_waddr     = r_cnt - ROW_W'(1);
                end
                n_prev = r_cur;
                n_cur  = rd_row;
                n_cnt  = r_cnt + ROW_W'(1);
            end
            ST_LAST: begin
                // bottom row sees dead cells below
                rule_below    = '0;
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = ROW_W'(GRID_HEIGHT - 1);
                n_state       = ST_REPLY;
            end
            ST_REPLY: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
        end
    end

    // item and window registers
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_addr    <= n_addr;
        r_col     <= n_col;
        r_val     <= n_val;
        r_is_read <= n_is_read;
        r_res     <= n_res;
        r_prev    <= n_prev;
        r_cur     <= n_cur;
        if (out_load) begin
            r_cell_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_out  = r_cell_out;

`ifndef SYNTHESIS
    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted while one is in work");

    // the row counter stays inside the grid during a sweep
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_cnt <= ROW_W'(GRID_HEIGHT - 1)))
        else $error("sweep row counter beyond grid");

    // a waiting result is not overwritten
    a_reply_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPLY && r_out_valid && i_out_stall) |=> (r_state == ST_REPLY))
        else $error("result loaded over a held result");
`endif

endmodule

`default_nettype wire
